// ===== design/nsr_pkg.sv =====
`default_nettype none

package nsr_pkg;

    localparam int DATA_W   = 8;
    localparam int LEN_W    = 7;
    localparam int COUNT_W  = 16;
    localparam int INDEX_W  = 2;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 4;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MISMATCH  = 3'd1,
        ST_NOFIELD   = 3'd2,
        ST_SHORT     = 3'd3,
        ST_UNCHECKED = 3'd4
    } status_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_USE_CHECKSUM = 2'd0,
        REG_START_CHAR_A = 2'd1,
        REG_START_CHAR_B = 2'd2
    } reg_index_t;

    localparam logic [DATA_W-1:0] CHAR_STAR   = 8'h2A;
    localparam logic [DATA_W-1:0] CHAR_CR     = 8'h0D;
    localparam logic [DATA_W-1:0] CHAR_LF     = 8'h0A;
    localparam logic [DATA_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [DATA_W-1:0] CHAR_A      = 8'h41;
    localparam logic [DATA_W-1:0] NIBBLE_MASK = 8'h0F;
    localparam logic [DATA_W-1:0] START_A_RST = 8'h24;
    localparam logic [DATA_W-1:0] START_B_RST = 8'h21;
    localparam logic [LEN_W-1:0]  SHORT_MAX   = 7'd3;

    function automatic logic [DATA_W-1:0] hex_digit(input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] nib;
        nib = value & NIBBLE_MASK;
        if (nib < 8'd10) begin
            hex_digit = nib + CHAR_ZERO;
        end else begin
            hex_digit = (nib - 8'd10) + CHAR_A;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/nmea_sentence_receiver.sv =====
// channel  | ports                          | item
// ---------+--------------------------------+----------------------------------------
// input    | s_tvalid s_tready s_tdata      | rx_byte
// result   | m_tvalid m_tready m_tdata      | data_byte checksum sentence_length
//          | m_tlast m_tuser                | error_count; last; is_body status
// config   | cfg_valid cfg_ready cfg_index  | register write, cfg_ready always high
//          | cfg_data                       |
//
// one byte per cycle while s_tready is high: sentence state updates in the accept cycle, result register follows
// result shows in the cycle after its byte is accepted, no delay beyond that register
// s_tready drops only while a result waits in the register and m_tready is low
// aresetn is synchronous: clears phase, sums, counters, config registers and m_tvalid to their defaults
`default_nettype none

module nmea_sentence_receiver
    import nsr_pkg::*;
#(
    parameter int LINE_LIMIT = 128
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [DATA_W-1:0]    s_tdata,   // [7:0] rx_byte

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_DATA_W-1:0]       m_tdata,   // [7:0] data_byte, [15:8] checksum,
                                                 // [22:16] sentence_length,
                                                 // [38:23] error_count, [39] zero
    output logic                      m_tlast,   // last
    output logic [M_USER_W-1:0]       m_tuser,   // [0] is_body, [3:1] status

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [INDEX_W-1:0]   cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data
);

    localparam int CAP_INT = (LINE_LIMIT - 1 < 127) ? LINE_LIMIT - 1 : 127;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CAP_INT);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BODY  = 2'd1,
        PH_FIELD = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [DATA_W-1:0]   xor_sum;
        logic [1:0]          digits_seen;
        logic                high_match;
        logic                low_match;
        logic [LEN_W-1:0]    length_count;
    } sentence_t;

    localparam sentence_t SENTENCE_CLEAR = '{
        phase: PH_IDLE, xor_sum: '0, digits_seen: 2'd0,
        high_match: 1'b0, low_match: 1'b0, length_count: '0
    };

    function automatic sentence_t take_content(input sentence_t cur,
                                               input logic [DATA_W-1:0] b);
        sentence_t nxt;
        nxt = cur;
        if (cur.length_count < LEN_CAP) begin
            nxt.length_count = cur.length_count + LEN_W'(1);
        end
        case (cur.phase)
            PH_BODY: begin
                if (b == CHAR_STAR) begin
                    nxt.phase = PH_FIELD;
                end else begin
                    nxt.xor_sum = cur.xor_sum ^ b;
                end
            end
            PH_FIELD: begin
                if (cur.digits_seen == 2'd0) begin
                    nxt.high_match  = (b == hex_digit(cur.xor_sum >> 4));
                    nxt.digits_seen = 2'd1;
                end else if (cur.digits_seen == 2'd1) begin
                    nxt.low_match   = (b == hex_digit(cur.xor_sum));
                    nxt.digits_seen = 2'd2;
                end
            end
            default: begin
                nxt = cur;
            end
        endcase
        return nxt;
    endfunction

    logic                 use_checksum_reg;
    logic [DATA_W-1:0]    start_a_reg;
    logic [DATA_W-1:0]    start_b_reg;

    sentence_t            sent_reg, sent_next;
    logic                 prev_cr_reg, prev_cr_next;
    logic [COUNT_W-1:0]   fail_reg, fail_next;

    logic                 m_valid_reg;
    logic [DATA_W-1:0]    m_byte_reg;
    logic                 m_body_reg;
    logic                 m_last_reg;
    status_t              m_status_reg;
    logic [DATA_W-1:0]    m_sum_reg;
    logic [LEN_W-1:0]     m_len_reg;
    logic [COUNT_W-1:0]   m_fail_reg;

    logic                 accept;
    logic                 is_start;
    logic                 is_end;
    logic                 emit;
    logic                 body_flag;
    status_t              status_next;
    sentence_t            after_cr;
    sentence_t            shown;

    assign s_tready  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    assign is_start = (s_tdata == start_a_reg) || (s_tdata == start_b_reg);
    assign is_end   = (s_tdata == CHAR_LF) && prev_cr_reg;
    assign emit     = is_start || (sent_reg.phase != PH_IDLE);

    always_comb begin
        sent_next    = sent_reg;
        prev_cr_next = prev_cr_reg;
        fail_next    = fail_reg;
        status_next  = ST_OK;
        body_flag    = 1'b0;
        after_cr     = sent_reg;
        shown        = sent_reg;
        if (is_start) begin
            sent_next              = SENTENCE_CLEAR;
            sent_next.phase        = PH_BODY;
            sent_next.length_count = LEN_W'(1);
            prev_cr_next           = 1'b0;
            shown                  = sent_next;
        end else if (sent_reg.phase != PH_IDLE) begin
            if (is_end) begin
                if (sent_reg.length_count <= SHORT_MAX) begin
                    status_next = ST_SHORT;
                end else if (!use_checksum_reg) begin
                    status_next = ST_UNCHECKED;
                end else if (sent_reg.phase != PH_FIELD) begin
                    status_next = ST_NOFIELD;
                end else if (sent_reg.digits_seen == 2'd2 && sent_reg.high_match
                             && sent_reg.low_match) begin
                    status_next = ST_OK;
                end else begin
                    status_next = ST_MISMATCH;
                    if (fail_reg != '1) begin
                        fail_next = fail_reg + COUNT_W'(1);
                    end
                end
                sent_next    = SENTENCE_CLEAR;
                prev_cr_next = 1'b0;
            end else begin
                // a held cr counts as content once the next byte is not lf
                if (prev_cr_reg) begin
                    after_cr = take_content(sent_reg, CHAR_CR);
                end
                body_flag = (after_cr.phase == PH_BODY) && (s_tdata != CHAR_STAR);
                if (s_tdata == CHAR_CR) begin
                    sent_next    = after_cr;
                    prev_cr_next = 1'b1;
                end else begin
                    sent_next    = take_content(after_cr, s_tdata);
                    prev_cr_next = 1'b0;
                end
                shown = sent_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_checksum_reg <= 1'b1;
            start_a_reg      <= START_A_RST;
            start_b_reg      <= START_B_RST;
            sent_reg         <= SENTENCE_CLEAR;
            prev_cr_reg      <= 1'b0;
            fail_reg         <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_USE_CHECKSUM: use_checksum_reg <= cfg_data[0];
                    REG_START_CHAR_A: start_a_reg      <= cfg_data;
                    REG_START_CHAR_B: start_b_reg      <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                sent_reg     <= sent_next;
                prev_cr_reg  <= prev_cr_next;
                fail_reg     <= fail_next;
                m_byte_reg   <= s_tdata;
                m_body_reg   <= body_flag;
                m_last_reg   <= is_end && !is_start;
                m_status_reg <= status_next;
                m_sum_reg    <= shown.xor_sum;
                m_len_reg    <= shown.length_count;
                m_fail_reg   <= fail_next;
            end
            if (s_tready) begin
                m_valid_reg <= accept && emit;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_status_reg, m_body_reg};
    assign m_tdata  = {1'b0, m_fail_reg, m_len_reg, m_sum_reg, m_byte_reg};

endmodule

`default_nettype wire

// ===== design/nsr_checker.sv =====
`default_nettype none

module nsr_checker
    import nsr_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_DATA_W-1:0]  m_tdata,
    input wire logic                 m_tlast,
    input wire logic [M_USER_W-1:0]  m_tuser
);

    a_reset_clears_valid: assert property (
        @(posedge aclk) !aresetn |=> !m_tvalid
    ) else $error("result valid after reset");

    a_status_only_on_last: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[3:1] == ST_OK
    ) else $error("status set on a non-final item");

    a_last_not_body: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tuser[0]
    ) else $error("closing item marked as body");

    a_status_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[3:1] <= ST_UNCHECKED
    ) else $error("status code out of range");

    a_stall_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
    ) else $error("stalled result changed");

endmodule

bind nmea_sentence_receiver nsr_checker u_nsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
